@@ hdl/sfr_pkg.sv @@
// shared types, constants and crc function of the frame receiver
package sfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 7;
  localparam int CRC_W   = 16;
  localparam int RAW_W   = 16;
  localparam int PULSE_W = 20;
  localparam int IDX_W   = 4;
  localparam int SLOT_W  = 6;

  localparam logic [CRC_W-1:0]   CRC_POLY      = 16'h1021;
  localparam logic [PULSE_W-1:0] PULSE_OFFSET  = 20'd11580;
  localparam logic [CNT_W-1:0]   FRAME_LEN_RST = 7'd37;
  localparam logic [CNT_W-1:0]   CHAN_FIRST    = 7'd3;

  // one command from the front to the back
  typedef struct packed {
    logic              wr_en;
    logic              wr_hi;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] data;
    logic              done;
    logic              crc_ok;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_e;

  // crc-16, polynomial 0x1021, msb first, one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ hdl/sfr_byte_if.sv @@
// byte input channel interface
interface sfr_byte_if import sfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

@@ hdl/sfr_chan_if.sv @@
// channel result output interface
interface sfr_chan_if import sfr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [IDX_W-1:0]          channel_index;
  logic [RAW_W-1:0]          channel_raw;
  logic signed [PULSE_W-1:0] pulse_q8;
  logic                      crc_ok;
  logic                      last;

  modport source (output valid, output channel_index, output channel_raw,
                  output pulse_q8, output crc_ok, output last, input ready);
  modport sink (input valid, input channel_index, input channel_raw,
                input pulse_q8, input crc_ok, input last, output ready);
endinterface

@@ hdl/sfr_front.sv @@
// front end: byte count, crc and classification of each byte into a command
module sfr_front import sfr_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sfr_byte_if.sink         byte_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             queue_full_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  logic [CNT_W-1:0] frame_len_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CRC_W-1:0] crc_q, crc_d;

  logic [CNT_W-1:0] cnt_eff, cnt_new, rel;
  logic [CRC_W-1:0] crc_eff, crc_new;
  logic             take, in_area, accept;

  assign byte_i.ready = !queue_full_i;
  assign accept       = byte_i.valid && byte_i.ready;

  // start flag clears count and crc before the byte is taken
  always_comb begin
    cnt_eff = byte_i.frame_start ? '0 : count_q;
    crc_eff = byte_i.frame_start ? '0 : crc_q;
    take    = cnt_eff < frame_len_q;
    crc_new = crc_byte(crc_eff, byte_i.rx_byte);
    cnt_new = cnt_eff + 7'd1;
    rel     = cnt_eff - CHAN_FIRST;
    in_area = (cnt_eff >= CHAN_FIRST) &&
              ({1'b0, rel[CNT_W-1:1]} < CNT_W'(NUM_CHANNELS));
    count_d = take ? cnt_new : cnt_eff;
    crc_d   = take ? crc_new : crc_eff;
  end

  // command for the back end
  always_comb begin
    cmd_o.wr_en  = take && in_area;
    cmd_o.wr_hi  = !rel[0];
    cmd_o.slot   = rel[CNT_W-1:1];
    cmd_o.data   = byte_i.rx_byte;
    cmd_o.done   = take && (cnt_new == frame_len_q);
    cmd_o.crc_ok = (crc_new == '0);
    push_o       = accept && (cmd_o.wr_en || cmd_o.done);
  end

  // frame length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= FRAME_LEN_RST;
    end else if (cfg_we_i) begin
      frame_len_q <= cfg_wdata_i;
    end
  end

  // count and crc registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= '0;
    end else if (accept) begin
      count_q <= count_d;
      crc_q   <= crc_d;
    end
  end

endmodule

@@ hdl/sfr_queue.sv @@
// two-entry command queue between front and back
module sfr_queue import sfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // fill level
  always_comb begin
    cnt_d = cnt_q;
    priority if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ hdl/sfr_back.sv @@
// back end: channel store and burst of channel results
module sfr_back import sfr_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       pop_o,
  sfr_chan_if.source chan_o
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_K = CH_W'(NUM_CHANNELS - 1);

  logic [RAW_W-1:0] store_q [NUM_CHANNELS];

  back_state_e               state_q, state_d;
  logic [CH_W-1:0]           k_q, k_d;
  logic                      ok_q, ok_d;
  logic                      load;
  logic                      out_valid_q;
  logic [IDX_W-1:0]          out_idx_q;
  logic [RAW_W-1:0]          out_raw_q;
  logic signed [PULSE_W-1:0] out_pulse_q;
  logic                      out_ok_q, out_last_q;
  logic [RAW_W-1:0]          raw;
  logic [PULSE_W-1:0]        raw5;
  logic [CH_W-1:0]           wr_idx;

  assign raw    = store_q[k_q];
  assign raw5   = {4'b0, raw} + {2'b0, raw, 2'b0};
  assign wr_idx = q_cmd_i.slot[CH_W-1:0];

  // sequencer: execute commands, then run the burst
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    ok_d    = ok_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o = 1'b1;
          if (q_cmd_i.done) begin
            state_d = BK_EMIT;
            k_d     = '0;
            ok_d    = q_cmd_i.crc_ok;
          end
        end
      end
      BK_EMIT: begin
        if (!out_valid_q || chan_o.ready) begin
          load = 1'b1;
          if (k_q == LAST_K) begin
            state_d = BK_IDLE;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      k_q     <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      ok_q    <= ok_d;
    end
  end

  // channel store, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        store_q[i] <= '0;
      end
    end else if (pop_o && q_cmd_i.wr_en) begin
      if (q_cmd_i.wr_hi) begin
        store_q[wr_idx][15:8] <= q_cmd_i.data;
      end else begin
        store_q[wr_idx][7:0] <= {3'b000, q_cmd_i.data[7:3]};
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_idx_q   <= IDX_W'(k_q);
      out_raw_q   <= raw;
      out_pulse_q <= signed'(raw5 - PULSE_OFFSET);
      out_ok_q    <= ok_q;
      out_last_q  <= (k_q == LAST_K);
    end
  end

  assign chan_o.valid         = out_valid_q;
  assign chan_o.channel_index = out_idx_q;
  assign chan_o.channel_raw   = out_raw_q;
  assign chan_o.pulse_q8      = out_pulse_q;
  assign chan_o.crc_ok        = out_ok_q;
  assign chan_o.last          = out_last_q;

endmodule

@@ hdl/sumd_frame_receiver_top.sv @@
// top level of the byte-serial radio frame receiver
//
// Bytes come in on byte_i (valid/ready, one transfer per byte, frame_start
// marks byte 0). The front end takes one byte a cycle while the queue is not
// full, runs the crc-16 over it and turns channel bytes and the frame end into
// commands for a two-entry queue. The back end writes the channel store and,
// at a frame end, sends NUM_CHANNELS results on chan_o, one per cycle while
// the sink is ready, through its single output register, the first one once
// the frame end command has passed the queue and the sequencer state. When
// chan_o stalls, the output register holds its result; the front keeps
// taking bytes until the queue holds two commands, then drops byte_i.ready.
// Reset clears count, crc, queue, store and output valid and loads a frame
// length of 37. cfg_we_i writes the frame length; the user must do so only
// while the block is idle, as the block itself does not enforce this.
module sumd_frame_receiver_top import sfr_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sfr_byte_if.sink         byte_i,
  sfr_chan_if.source       chan_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  logic push, q_full, q_valid, pop;
  cmd_t push_cmd, pop_cmd;

  // classify bytes
  sfr_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .queue_full_i (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // command queue
  sfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  // store and result burst
  sfr_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (pop_cmd),
    .pop_o     (pop),
    .chan_o    (chan_o)
  );

  // no push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("command pushed into full queue");

  // the last flag sits on the final channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chan_o.valid && chan_o.last) |->
      (chan_o.channel_index == IDX_W'(NUM_CHANNELS - 1)))
    else $error("last flag on wrong channel");

  // the burst has no gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chan_o.valid && chan_o.ready && !chan_o.last) |=> chan_o.valid)
    else $error("gap inside result burst");

endmodule
